// File: hw/rtl/fpba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit-policy block allocator: shared package
// Widths, codes, words and state types used by the allocator and its testbench.
// ----------------------------------------------------------------------------
package fpba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W       = 24;
    localparam int PAGE_SHIFT   = 12;
    localparam int PAGE_BYTES   = 1 << PAGE_SHIFT;
    localparam int HEADER_BYTES = 32;
    localparam int SPLIT_SLACK  = 16;
    localparam int ROUND_MASK   = 15;
    localparam int LIMIT_W      = 13;
    localparam int NEED_W       = ADDR_W + 1;
    localparam int SUM_W        = ADDR_W + 2;

    // Highest heap end that keeps every size and address inside its field.
    localparam logic [NEED_W-1:0] HEAP_CAP = NEED_W'((1 << ADDR_W) - 16);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_SIZE = 3'd1,
        ST_NO_MEMORY = 3'd2,
        ST_TABLE_FULL= 3'd3,
        ST_DBL_FREE  = 3'd4,
        ST_UNKNOWN   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2,
        POL_SPARE = 2'd3
    } policy_t;

    typedef enum logic {
        REG_FIT_POLICY = 1'b0,
        REG_HEAP_LIMIT = 1'b1
    } reg_index_t;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_GROW,
        S_TAKE,
        S_SPLIT,
        S_FIN
    } state_t;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] request_bytes;
        logic [ADDR_W-1:0] release_address;
    } in_word_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] payload_address;
        logic [ADDR_W-1:0] granted_bytes;
    } out_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic              free;
    } entry_t;

endpackage

// File: hw/rtl/fpba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit-policy block allocator: table RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fpba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/fit_policy_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit-policy block allocator
// Heap allocator over an address-ordered block table held in two RAMs
// (block words and list links), with first, best or worst fit search.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   request | s_valid s_ready s_data         | in
//   result  | m_valid m_ready m_data         | out
//   config  | cfg_valid cfg_ready cfg_index  | in
//           | cfg_data                       |
//
// An allocation walks the table entries (up to 64) and then takes the pick;
// a split adds the split state and a heap growth adds the grow state. A
// release walks entries until its block or the last, and a zero-size request
// goes straight to the finish state. The list walk is set by the link RAM:
// each entry's link read steers the next read address.
// Reset leaves an empty table; no clearing pass is needed, as entries are
// handed out by a fill count. A stalled result waits in the output
// register while the next request is already being taken; that request
// then holds in its last cycle until the register drains.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator
    import fpba_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    state_t state_reg, state_next;

    logic [1:0]         policy_reg;
    logic [LIMIT_W-1:0] limit_pages_reg;

    logic              action_reg, action_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [ADDR_W-1:0] rel_reg, rel_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;

    logic              pick_valid_reg, pick_valid_next;
    logic [IDX_W-1:0]  pick_idx_reg, pick_idx_next;
    logic [ADDR_W-1:0] pick_start_reg, pick_start_next;
    logic [ADDR_W-1:0] pick_size_reg, pick_size_next;
    logic [IDX_W-1:0]  pick_link_reg, pick_link_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  last_reg, last_next;
    logic [ADDR_W-1:0] heap_end_reg, heap_end_next;

    out_word_t res_reg, res_next;
    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg, m_data_next;

    // RAM ports.
    logic             data_we, link_we;
    logic [IDX_W-1:0] data_waddr, link_waddr, rd_addr;
    entry_t           data_wdata, ent;
    logic [IDX_W-1:0] link_wdata, link_rdata;

    // Datapath helpers.
    logic [NEED_W-1:0] need_calc, grow;
    logic [SUM_W-1:0]  limit, grow_end, split_bound;
    logic              hit, better, at_last, split;
    logic [ADDR_W-1:0] payload_of_ent;

    fpba_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_BLOCKS)) u_data_ram (
        .aclk  (aclk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (rd_addr),
        .rdata (ent)
    );

    fpba_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BLOCKS)) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (rd_addr),
        .rdata (link_rdata)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // The walk starts at the head entry and then follows the link just read.
    assign rd_addr = (state_reg == S_WALK) ? link_rdata : '0;

    // Size rounding, growth amount and heap limit.
    assign need_calc = ((NEED_W'(s_data.request_bytes) + NEED_W'(ROUND_MASK))
                        & ~NEED_W'(ROUND_MASK)) + NEED_W'(HEADER_BYTES);
    assign grow      = (need_reg < NEED_W'(PAGE_BYTES)) ? NEED_W'(PAGE_BYTES) : need_reg;
    always_comb begin
        limit = SUM_W'(limit_pages_reg) << PAGE_SHIFT;
        if (limit > SUM_W'(HEAP_CAP)) begin
            limit = SUM_W'(HEAP_CAP);
        end
    end
    assign grow_end    = SUM_W'(heap_end_reg) + SUM_W'(grow);
    assign split_bound = SUM_W'(need_reg) + SUM_W'(HEADER_BYTES + SPLIT_SLACK);
    assign split       = (SUM_W'(pick_size_reg) > split_bound)
                         && (count_reg != CNT_W'(MAX_BLOCKS));

    // Fit test on the entry currently out of the RAM.
    assign hit     = ent.free && (NEED_W'(ent.size) >= need_reg);
    assign at_last = (cur_reg == last_reg);
    assign payload_of_ent = ent.start + ADDR_W'(HEADER_BYTES);
    always_comb begin
        case (policy_reg)
            POL_BEST:  better = !pick_valid_reg || (ent.size < pick_size_reg);
            POL_WORST: better = !pick_valid_reg || (ent.size > pick_size_reg);
            default:   better = 1'b1;
        endcase
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_data.action == ACT_ALLOC && s_data.request_bytes == '0) begin
                        state_next = S_FIN;
                    end else if (count_reg == '0) begin
                        state_next = (s_data.action == ACT_ALLOC) ? S_GROW : S_FIN;
                    end else begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (action_reg == ACT_ALLOC) begin
                    if (hit && (policy_reg != POL_BEST) && (policy_reg != POL_WORST)) begin
                        state_next = S_TAKE;
                    end else if (at_last) begin
                        state_next = (pick_valid_reg || (hit && better)) ? S_TAKE : S_GROW;
                    end
                end else if (payload_of_ent == rel_reg || at_last) begin
                    state_next = S_FIN;
                end
            end
            S_GROW: begin
                if (grow_end > limit || count_reg == CNT_W'(MAX_BLOCKS)) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_TAKE;
                end
            end
            S_TAKE:  state_next = split ? S_SPLIT : S_FIN;
            S_SPLIT: state_next = S_FIN;
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        action_next     = action_reg;
        need_next       = need_reg;
        rel_next        = rel_reg;
        cur_next        = cur_reg;
        pick_valid_next = pick_valid_reg;
        pick_idx_next   = pick_idx_reg;
        pick_start_next = pick_start_reg;
        pick_size_next  = pick_size_reg;
        pick_link_next  = pick_link_reg;
        count_next      = count_reg;
        last_next       = last_reg;
        heap_end_next   = heap_end_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        data_we         = 1'b0;
        data_waddr      = pick_idx_reg;
        data_wdata      = '{start: pick_start_reg, size: pick_size_reg, free: 1'b0};
        link_we         = 1'b0;
        link_waddr      = pick_idx_reg;
        link_wdata      = pick_link_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    action_next     = s_data.action;
                    need_next       = need_calc;
                    rel_next        = s_data.release_address;
                    cur_next        = '0;
                    pick_valid_next = 1'b0;
                    res_next        = '0;
                    if (s_data.action == ACT_ALLOC) begin
                        res_next.status = (s_data.request_bytes == '0) ? ST_ZERO_SIZE : ST_OK;
                    end else begin
                        res_next.status = ST_UNKNOWN;
                    end
                end
            end
            S_WALK: begin
                cur_next = link_rdata;
                if (action_reg == ACT_ALLOC) begin
                    if (hit && better) begin
                        pick_valid_next = 1'b1;
                        pick_idx_next   = cur_reg;
                        pick_start_next = ent.start;
                        pick_size_next  = ent.size;
                        pick_link_next  = link_rdata;
                    end
                end else if (payload_of_ent == rel_reg) begin
                    // Matching block: release it unless it is already free.
                    if (ent.free) begin
                        res_next.status = ST_DBL_FREE;
                    end else begin
                        res_next.status = ST_OK;
                        data_we    = 1'b1;
                        data_waddr = cur_reg;
                        data_wdata = '{start: ent.start, size: ent.size, free: 1'b1};
                    end
                end
            end
            S_GROW: begin
                if (grow_end > limit) begin
                    res_next.status = ST_NO_MEMORY;
                end else if (count_reg == CNT_W'(MAX_BLOCKS)) begin
                    res_next.status = ST_TABLE_FULL;
                end else begin
                    // Append a fresh block at the heap end and make it the pick.
                    link_we         = (count_reg != '0);
                    link_waddr      = last_reg;
                    link_wdata      = count_reg[IDX_W-1:0];
                    pick_idx_next   = count_reg[IDX_W-1:0];
                    pick_start_next = heap_end_reg;
                    pick_size_next  = grow[ADDR_W-1:0];
                    pick_link_next  = '0;
                    last_next       = count_reg[IDX_W-1:0];
                    count_next      = count_reg + 1'b1;
                    heap_end_next   = grow_end[ADDR_W-1:0];
                end
            end
            S_TAKE: begin
                // Mark the chosen block used, trimmed to the need when it splits.
                data_we    = 1'b1;
                link_we    = 1'b1;
                data_wdata = '{start: pick_start_reg,
                               size:  split ? need_reg[ADDR_W-1:0] : pick_size_reg,
                               free:  1'b0};
                link_wdata = split ? count_reg[IDX_W-1:0] : pick_link_reg;
                res_next.status          = ST_OK;
                res_next.payload_address = pick_start_reg + ADDR_W'(HEADER_BYTES);
                res_next.granted_bytes   = split ? need_reg[ADDR_W-1:0] : pick_size_reg;
            end
            S_SPLIT: begin
                // The tail becomes a new free entry right after the chosen one.
                data_we    = 1'b1;
                data_waddr = count_reg[IDX_W-1:0];
                data_wdata = '{start: pick_start_reg + need_reg[ADDR_W-1:0],
                               size:  pick_size_reg - need_reg[ADDR_W-1:0],
                               free:  1'b1};
                link_we    = 1'b1;
                link_waddr = count_reg[IDX_W-1:0];
                link_wdata = pick_link_reg;
                if (last_reg == pick_idx_reg) begin
                    last_next = count_reg[IDX_W-1:0];
                end
                count_next = count_reg + 1'b1;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            last_reg        <= '0;
            heap_end_reg    <= '0;
            m_valid_reg     <= 1'b0;
            policy_reg      <= POL_FIRST;
            limit_pages_reg <= LIMIT_W'(4096);
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            last_reg     <= last_next;
            heap_end_reg <= heap_end_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_FIT_POLICY: policy_reg      <= cfg_data[1:0];
                    default:        limit_pages_reg <= cfg_data;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        action_reg     <= action_next;
        need_reg       <= need_next;
        rel_reg        <= rel_next;
        cur_reg        <= cur_next;
        pick_valid_reg <= pick_valid_next;
        pick_idx_reg   <= pick_idx_next;
        pick_start_reg <= pick_start_next;
        pick_size_reg  <= pick_size_next;
        pick_link_reg  <= pick_link_next;
        res_reg        <= res_next;
        m_data_reg     <= m_data_next;
    end

    // Checks.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block table count beyond its depth");

    a_heap_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        NEED_W'(heap_end_reg) <= HEAP_CAP)
        else $error("heap end beyond the address cap");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while one is in progress");

    a_empty_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |-> count_reg != '0)
        else $error("walk started over an empty table");

endmodule

// File: sim/fit_policy_block_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fit-policy block allocator testbench
// A directed table covers the edge cases: zero size, exhausted heap, double
// free and unknown addresses. Random phases then follow under every fit
// policy and several heap limits. Each result word is checked field by field
// against an in-bench model of the block table, with random idle gaps on
// both the request and the result channel.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_tb;
    import fpba_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_word_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_word_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_FIT_POLICY;
    logic [12:0] cfg_data = '0;

    fit_policy_block_allocator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial begin
        forever #1 aclk = ~aclk;
    end

    // Watchdog against a hung handshake.
    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    // Shadow copy of the block table and the configuration.
    logic [ADDR_W-1:0] blk_start [MAX_BLOCKS];
    longint unsigned   blk_size  [MAX_BLOCKS];
    logic              blk_free  [MAX_BLOCKS];
    int                blk_link  [MAX_BLOCKS];
    logic              blk_taken [MAX_BLOCKS];
    int                list_head = 0;
    int                list_tail = 0;
    logic              list_none = 1'b1;
    longint unsigned   heap_top  = 0;
    policy_t           cur_policy = POL_FIRST;
    longint unsigned   cur_pages  = 4096;

    out_word_t         results_due [$];
    logic [ADDR_W-1:0] live_payloads [$];
    int                errors = 0;
    logic              burst_mode = 1'b0;

    function automatic int spare_slot();
        for (int i = 0; i < MAX_BLOCKS; i++)
            if (!blk_taken[i]) return i;
        return -1;
    endfunction

    // Walk the list in address order and pick a free block by policy.
    function automatic int search_fit(longint unsigned need);
        int pick;
        int cur;
        pick = -1;
        cur = list_head;
        if (list_none) return -1;
        for (int steps = 0; steps < MAX_BLOCKS; steps++) begin
            if (blk_free[cur] && blk_size[cur] >= need) begin
                if (cur_policy == POL_BEST) begin
                    if (pick < 0 || blk_size[cur] < blk_size[pick]) pick = cur;
                end else if (cur_policy == POL_WORST) begin
                    if (pick < 0 || blk_size[cur] > blk_size[pick]) pick = cur;
                end else begin
                    return cur;
                end
            end
            if (cur == list_tail) break;
            cur = blk_link[cur];
        end
        return pick;
    endfunction

    // Work out the result word for one request and update the table.
    function automatic out_word_t predict_result(in_word_t w);
        out_word_t       r;
        longint unsigned need;
        longint unsigned grow;
        longint unsigned lim;
        int              idx;
        int              n;
        int              cur;
        r = '0;
        if (w.action == ACT_ALLOC) begin
            if (w.request_bytes == 0) begin
                r.status = ST_ZERO_SIZE;
                return r;
            end
            need = ((longint'(w.request_bytes) + ROUND_MASK) & ~longint'(ROUND_MASK))
                   + HEADER_BYTES;
            idx = search_fit(need);
            if (idx < 0) begin
                grow = (need < PAGE_BYTES) ? PAGE_BYTES : need;
                lim = cur_pages * PAGE_BYTES;
                if (lim > (64'd1 << ADDR_W) - 16) lim = (64'd1 << ADDR_W) - 16;
                if (heap_top + grow > lim) begin
                    r.status = ST_NO_MEMORY;
                    return r;
                end
                idx = spare_slot();
                if (idx < 0) begin
                    r.status = ST_TABLE_FULL;
                    return r;
                end
                blk_taken[idx] = 1'b1;
                blk_start[idx] = heap_top[ADDR_W-1:0];
                blk_size[idx]  = grow;
                blk_free[idx]  = 1'b1;
                blk_link[idx]  = 0;
                if (list_none) begin
                    list_head = idx;
                    list_none = 1'b0;
                end else begin
                    blk_link[list_tail] = idx;
                end
                list_tail = idx;
                heap_top += grow;
            end
            // Split off the tail when enough is left over and a slot is spare.
            if (blk_size[idx] > need + HEADER_BYTES + SPLIT_SLACK) begin
                n = spare_slot();
                if (n >= 0) begin
                    blk_taken[n] = 1'b1;
                    blk_start[n] = blk_start[idx] + need[ADDR_W-1:0];
                    blk_size[n]  = blk_size[idx] - need;
                    blk_free[n]  = 1'b1;
                    blk_link[n]  = blk_link[idx];
                    if (list_tail == idx) list_tail = n;
                    blk_size[idx] = need;
                    blk_link[idx] = n;
                end
            end
            blk_free[idx] = 1'b0;
            r.status = ST_OK;
            r.payload_address = blk_start[idx] + ADDR_W'(HEADER_BYTES);
            r.granted_bytes = blk_size[idx][ADDR_W-1:0];
            return r;
        end
        // Release: look the payload address up along the list.
        r.status = ST_UNKNOWN;
        if (!list_none) begin
            cur = list_head;
            for (int steps = 0; steps < MAX_BLOCKS; steps++) begin
                if (blk_start[cur] + ADDR_W'(HEADER_BYTES) == w.release_address) begin
                    if (blk_free[cur]) begin
                        r.status = ST_DBL_FREE;
                    end else begin
                        blk_free[cur] = 1'b1;
                        r.status = ST_OK;
                    end
                    return r;
                end
                if (cur == list_tail) break;
                cur = blk_link[cur];
            end
        end
        return r;
    endfunction

    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, 11);
    endfunction

    // Result side: random stalls, then compare against the oldest expectation.
    int stall_left = 0;
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_data);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    if (m_data.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_data.status);
                        errors++;
                    end
                    if (m_data.payload_address !== want.payload_address) begin
                        $display("%0t: payload_address expected %h actual %h",
                                 $time, want.payload_address, m_data.payload_address);
                        errors++;
                    end
                    if (m_data.granted_bytes !== want.granted_bytes) begin
                        $display("%0t: granted_bytes expected %h actual %h",
                                 $time, want.granted_bytes, m_data.granted_bytes);
                        errors++;
                    end
                end
                stall_left = draw_gap();
                m_ready <= (stall_left == 0);
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= (stall_left == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Present one request word, hold it until taken, then idle a while.
    task automatic send_word(input in_word_t w, output out_word_t got);
        int gap;
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        got = predict_result(w);
        results_due.push_back(got);
        if (w.action == ACT_ALLOC && got.status == ST_OK)
            live_payloads.push_back(got.payload_address);
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Register write, only once every result is back and the block is quiet.
    task automatic write_reg(input reg_index_t idx, input logic [12:0] value);
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_FIT_POLICY) cur_policy = policy_t'(value[1:0]);
        else cur_pages = 64'(value);
        cfg_valid <= 1'b0;
    endtask

    typedef struct {
        logic              action;
        logic [ADDR_W-1:0] req;
        logic [ADDR_W-1:0] rel;
        logic              typed;
        status_t           st;
        logic [ADDR_W-1:0] pa;
        logic [ADDR_W-1:0] gb;
    } stim_row_t;

    localparam int N_ROWS = 20;
    stim_row_t directed [N_ROWS] = '{
        '{ACT_ALLOC, 24'd0,        24'd0,        1'b1, ST_ZERO_SIZE, 24'd0,  24'd0},
        '{ACT_FREE,  24'd0,        24'd0,        1'b1, ST_UNKNOWN,   24'd0,  24'd0},
        '{ACT_ALLOC, 24'd1,        24'd0,        1'b1, ST_OK,        24'd32, 24'd48},
        '{ACT_ALLOC, 24'hFFFFFF,   24'd0,        1'b1, ST_NO_MEMORY, 24'd0,  24'd0},
        '{ACT_FREE,  24'd0,        24'd32,       1'b1, ST_OK,        24'd0,  24'd0},
        '{ACT_FREE,  24'd0,        24'd32,       1'b1, ST_DBL_FREE,  24'd0,  24'd0},
        '{ACT_FREE,  24'd0,        24'd33,       1'b1, ST_UNKNOWN,   24'd0,  24'd0},
        '{ACT_ALLOC, 24'd16,       24'd0,        1'b1, ST_OK,        24'd32, 24'd48},
        '{ACT_ALLOC, 24'd100,      24'hFFFFFF,   1'b0, ST_OK,        24'd0,  24'd0},
        '{ACT_ALLOC, 24'd5000,     24'd0,        1'b0, ST_OK,        24'd0,  24'd0},
        '{ACT_ALLOC, 24'd4000,     24'd0,        1'b0, ST_OK,        24'd0,  24'd0},
        '{ACT_ALLOC, 24'd17,       24'd0,        1'b0, ST_OK,        24'd0,  24'd0},
        '{ACT_ALLOC, 24'd15,       24'd0,        1'b0, ST_OK,        24'd0,  24'd0},
        '{ACT_FREE,  24'd0,        24'hFFFFFF,   1'b1, ST_UNKNOWN,   24'd0,  24'd0},
        '{ACT_FREE,  24'd0,        24'h800020,   1'b1, ST_UNKNOWN,   24'd0,  24'd0},
        '{ACT_ALLOC, 24'hFFFFC0,   24'd0,        1'b1, ST_NO_MEMORY, 24'd0,  24'd0},
        '{ACT_FREE,  24'hFFFFFF,   24'd80,       1'b0, ST_OK,        24'd0,  24'd0},
        '{ACT_FREE,  24'd0,        24'd80,       1'b0, ST_OK,        24'd0,  24'd0},
        '{ACT_ALLOC, 24'd48,       24'd0,        1'b0, ST_OK,        24'd0,  24'd0},
        '{ACT_ALLOC, 24'd4064,     24'd0,        1'b0, ST_OK,        24'd0,  24'd0}
    };

    // Random phases: policy and heap limit for each, extremes included.
    localparam int N_PHASES = 7;
    logic [1:0]  phase_policy [N_PHASES] = '{POL_BEST, POL_WORST, POL_SPARE, POL_FIRST,
                                             POL_BEST, POL_WORST, POL_FIRST};
    logic [12:0] phase_pages  [N_PHASES] = '{13'd4096, 13'd4096, 13'd8191, 13'd1,
                                             13'd0, 13'd64, 13'd4096};

    initial begin
        in_word_t  w;
        out_word_t got;
        int        pick;
        int        dice;
        for (int i = 0; i < MAX_BLOCKS; i++) blk_taken[i] = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults written explicitly before the directed table.
        write_reg(REG_FIT_POLICY, 13'(POL_FIRST));
        write_reg(REG_HEAP_LIMIT, 13'd4096);
        foreach (directed[i]) begin
            w.action = directed[i].action;
            w.request_bytes = directed[i].req;
            w.release_address = directed[i].rel;
            send_word(w, got);
            if (directed[i].typed && (got.status != directed[i].st ||
                got.payload_address != directed[i].pa ||
                got.granted_bytes != directed[i].gb)) begin
                $display("%0t: row %0d expected %0d/%h/%h model gives %0d/%h/%h",
                         $time, i, directed[i].st, directed[i].pa, directed[i].gb,
                         got.status, got.payload_address, got.granted_bytes);
                errors++;
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_reg(REG_FIT_POLICY, {11'($urandom), phase_policy[ph]});
            write_reg(REG_HEAP_LIMIT, phase_pages[ph]);
            for (int k = 0; k < 270; k++) begin
                if (k % 60 == 0) burst_mode = ($urandom_range(0, 3) == 0);
                w = '0;
                w.request_bytes = 24'($urandom);
                w.release_address = 24'($urandom);
                dice = $urandom_range(0, 99);
                if (dice < 55) begin
                    // Allocation, mostly small sizes.
                    w.action = ACT_ALLOC;
                    dice = $urandom_range(0, 99);
                    if (dice < 70) w.request_bytes = 24'($urandom_range(1, 512));
                    else if (dice < 90) w.request_bytes = 24'($urandom_range(513, 8192));
                    else if (dice < 97) w.request_bytes = 24'($urandom_range(8193, 65536));
                    else if (dice < 98) w.request_bytes = '0;
                end else begin
                    w.action = ACT_FREE;
                    dice = $urandom_range(0, 99);
                    if (live_payloads.size() != 0 && dice < 85) begin
                        pick = $urandom_range(0, live_payloads.size() - 1);
                        w.release_address = live_payloads[pick];
                        // Occasionally keep it to provoke a double free.
                        if (dice < 70) live_payloads.delete(pick);
                        else if (dice >= 80) w.release_address += ADDR_W'(16);
                    end
                end
                send_word(w, got);
            end
        end
        s_valid <= 1'b0;

        while (results_due.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/fpba_pkg.sv
hw/rtl/fpba_ram.sv
hw/rtl/fit_policy_block_allocator.sv
sim/fit_policy_block_allocator_tb.sv
